/* rtl/core/sobel_edge_magnitude_threshold_core_defines.svh */
// ----------------------------------------------------------------------------
// sobel edge core assertion macros
// shared assertion wrappers clocked on clk_i, disabled during reset
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_THRESHOLD_CORE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_THRESHOLD_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define SOBEL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent on the next edge
`define SOBEL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sobel_pkg.sv */
// ----------------------------------------------------------------------------
// sobel_pkg
// shared types and constants of the sobel edge core
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned VAL_W          = 11;
  localparam int unsigned DIM_W          = 11;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned SQ_W           = 22;
  localparam int unsigned ROOT_STEPS     = SQ_W / 2;
  localparam logic [VAL_W-1:0] MAG_CLAMP = VAL_W'(2040);
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESH = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  typedef struct packed {
    col_t lft;
    col_t ctr;
    col_t rgt;
  } win_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] value;
  } mag_rsp_t;

endpackage

/* rtl/core/sobel_edge_magnitude_threshold_core.sv */
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_threshold_core
// streaming 3x3 sobel gradient magnitude with optional binary threshold
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one request at a time. Two line memories with
// a registered read hold the previous two rows; each pixel request reads both
// at its column, writes back and shifts a 3x3 window in the states S_PX_RD and
// S_PX_SH. Each result runs through the gradient unit: a start, the gradient,
// squaring of x and of y, the iterative square root in magnitude mode (skipped
// in threshold mode) and a done state; it then waits in the output register
// until taken. A request yields zero, one or two results. Flush requests
// drain the last row with three memory reads each.
`include "sobel_edge_magnitude_threshold_core_defines.svh"

module sobel_edge_magnitude_threshold_core
  import sobel_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // pixel[7:0]
  input  logic                 s_axis_tuser,   // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // edge_value[10:0], row_end, step_last
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PX_RD, S_PX_SH, S_FL_RD0, S_FL_RD1, S_FL_RD2, S_FL_CAP,
    S_RUN, S_WAIT, S_OUT
  } state_e;

  state_e           state_q;
  logic [PIX_W-1:0] thr_q;
  logic [DIM_W-1:0] wid_q, hgt_q;
  logic [RW-1:0]    row_q;
  logic [AW-1:0]    col_q;
  logic             flush_q;
  logic [PIX_W-1:0] px_q;
  col_t             win_q [3];
  win_t             job_q, job2_q;
  logic             re_q, fe_q, last_q, pend_q;
  logic             ovalid_q;
  logic [VAL_W-1:0] oval_q;
  logic             ore_q, ofe_q, olast_q;
  col_t             fl_l_q, fl_c_q;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_rd_q, mid_rd_q;
  logic [AW-1:0]    mem_addr;

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [31:0]      w_tmp, h_tmp;
  logic [AW-1:0]    xl, xr;
  logic             last_col;
  col_t             ncol, rd_col;
  mag_rsp_t         mag_rsp;

  always_comb begin
    w_tmp = 32'(wid_q);
    if (w_tmp < 32'd2) w_tmp = 32'd2;
    if (w_tmp > 32'(MAX_WIDTH)) w_tmp = 32'(MAX_WIDTH);
    w_eff = WW'(w_tmp);
    h_tmp = 32'(hgt_q);
    if (h_tmp < 32'd2) h_tmp = 32'd2;
    if (h_tmp > 32'(MAX_HEIGHT)) h_tmp = 32'(MAX_HEIGHT);
    h_eff = HW'(h_tmp);
    last_col = ((WW'(col_q) + WW'(1)) == w_eff);
    xl = (col_q == '0) ? AW'(1) : col_q - AW'(1);
    xr = last_col ? col_q : col_q + AW'(1);
    case (state_q)
      S_FL_RD0: mem_addr = xl;
      S_FL_RD2: mem_addr = xr;
      default:  mem_addr = col_q;
    endcase
    ncol.top = (row_q == RW'(1)) ? px_q : up_rd_q;
    ncol.mid = mid_rd_q;
    ncol.bot = px_q;
    rd_col.top = up_rd_q;
    rd_col.mid = mid_rd_q;
    rd_col.bot = mid_rd_q;
  end

  // line memories
  always_ff @(posedge clk_i) begin
    up_rd_q  <= upper_mem[mem_addr];
    mid_rd_q <= middle_mem[mem_addr];
    if (state_q == S_PX_RD) middle_mem[mem_addr] <= px_q;
    if (state_q == S_PX_SH) upper_mem[mem_addr] <= mid_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      thr_q    <= '0;
      wid_q    <= WIDTH_RST;
      hgt_q    <= HEIGHT_RST;
      row_q    <= '0;
      col_q    <= '0;
      flush_q  <= 1'b0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 3; i++) win_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESH: thr_q <= cfg_data_i[PIX_W-1:0];
          CFG_WIDTH, CFG_HEIGHT: begin
            if (cfg_idx_i == CFG_WIDTH) wid_q <= cfg_data_i;
            else hgt_q <= cfg_data_i;
            row_q   <= '0;
            col_q   <= '0;
            flush_q <= 1'b0;
          end
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            px_q <= s_axis_tdata;
            if (flush_q && s_axis_tuser == REQ_FLUSH) state_q <= S_FL_RD0;
            else if (!flush_q && s_axis_tuser == REQ_PIXEL) state_q <= S_PX_RD;
          end
        end
        S_PX_RD: state_q <= S_PX_SH;
        S_PX_SH: begin
          win_q[0] <= win_q[1];
          win_q[1] <= win_q[2];
          win_q[2] <= ncol;
          job_q.lft  <= (col_q == AW'(1)) ? ncol : win_q[1];
          job_q.ctr  <= win_q[2];
          job_q.rgt  <= ncol;
          job2_q.lft <= win_q[2];
          job2_q.ctr <= ncol;
          job2_q.rgt <= ncol;
          fe_q <= 1'b0;
          if (row_q != '0 && col_q != '0) begin
            re_q    <= 1'b0;
            last_q  <= !last_col;
            pend_q  <= last_col;
            state_q <= S_RUN;
          end else if (row_q != '0 && last_col) begin
            job_q.lft <= win_q[2];
            job_q.ctr <= ncol;
            re_q      <= 1'b1;
            last_q    <= 1'b1;
            pend_q    <= 1'b0;
            state_q   <= S_RUN;
          end else begin
            state_q <= S_IDLE;
          end
          if (last_col) begin
            col_q <= '0;
            if ((HW'(row_q) + HW'(1)) >= h_eff) begin
              row_q   <= RW'(h_eff - HW'(1));
              flush_q <= 1'b1;
            end else begin
              row_q <= row_q + RW'(1);
            end
          end else begin
            col_q <= col_q + AW'(1);
          end
        end
        S_FL_RD0: state_q <= S_FL_RD1;
        S_FL_RD1: begin
          fl_l_q  <= rd_col;
          state_q <= S_FL_RD2;
        end
        S_FL_RD2: begin
          fl_c_q  <= rd_col;
          state_q <= S_FL_CAP;
        end
        S_FL_CAP: begin
          job_q.lft <= fl_l_q;
          job_q.ctr <= fl_c_q;
          job_q.rgt <= rd_col;
          re_q      <= last_col;
          fe_q      <= last_col;
          last_q    <= 1'b1;
          pend_q    <= 1'b0;
          state_q   <= S_RUN;
          if (last_col) begin
            flush_q <= 1'b0;
            row_q   <= '0;
            col_q   <= '0;
          end else begin
            col_q <= col_q + AW'(1);
          end
        end
        S_RUN: state_q <= S_WAIT;
        S_WAIT: begin
          if (mag_rsp.done) begin
            oval_q   <= mag_rsp.value;
            ore_q    <= re_q;
            ofe_q    <= fe_q;
            olast_q  <= last_q;
            ovalid_q <= 1'b1;
            state_q  <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            ovalid_q <= 1'b0;
            if (pend_q) begin
              job_q   <= job2_q;
              re_q    <= 1'b1;
              fe_q    <= 1'b0;
              last_q  <= 1'b1;
              pend_q  <= 1'b0;
              state_q <= S_RUN;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  sobel_mag u_mag (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == S_RUN),
    .win_i    (job_q),
    .thresh_i (thr_q),
    .rsp_o    (mag_rsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, olast_q, ore_q, oval_q};
  assign m_axis_tlast  = ofe_q;

  `SOBEL_ASSERT(a_one_at_a_time, !(s_axis_tready && m_axis_tvalid), "input taken while result pending")
  `SOBEL_ASSERT(a_col_range, (WW'(col_q) < w_eff), "column count beyond row width")
  `SOBEL_ASSERT(a_done_in_wait, (!mag_rsp.done || state_q == S_WAIT), "unit result with no waiting job")
  `SOBEL_ASSERT_NEXT(a_thresh_flag, (state_q == S_WAIT && mag_rsp.done && thr_q != '0), (m_axis_tdata[10:1] == '0), "threshold result not a flag")

endmodule

/* rtl/core/sobel_mag.sv */
// ----------------------------------------------------------------------------
// sobel_mag
// gradient, squared magnitude and iterative square root or threshold
// ----------------------------------------------------------------------------
module sobel_mag
  import sobel_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  win_t             win_i,
  input  logic [PIX_W-1:0] thresh_i,
  output mag_rsp_t         rsp_o
);

  typedef enum logic [2:0] {
    U_IDLE, U_GRAD, U_SQX, U_SQY, U_ROOT, U_DONE
  } ustate_e;

  ustate_e          state_q;
  win_t             win_q;
  logic [9:0]       ax_q, ay_q;
  logic [15:0]      t2_q;
  logic [SQ_W-1:0]  sq_q, rad_q;
  logic [13:0]      rem_q;
  logic [VAL_W-1:0] root_q, val_q;
  logic [3:0]       cnt_q;

  logic [10:0]      gx, gy;
  logic [13:0]      rem_sh, trial;
  logic [13:0]      rem_n;
  logic [VAL_W-1:0] root_n;
  logic [SQ_W-1:0]  sq_y;

  always_comb begin
    gx = 11'(win_q.lft.top) - 11'(win_q.rgt.top)
       + ((11'(win_q.lft.mid) - 11'(win_q.rgt.mid)) << 1)
       + 11'(win_q.lft.bot) - 11'(win_q.rgt.bot);
    gy = 11'(win_q.lft.bot) + (11'(win_q.ctr.bot) << 1) + 11'(win_q.rgt.bot)
       - 11'(win_q.lft.top) - (11'(win_q.ctr.top) << 1) - 11'(win_q.rgt.top);
    sq_y   = sq_q + SQ_W'(ay_q * ay_q);
    rem_sh = {rem_q[11:0], rad_q[SQ_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_n  = rem_sh - trial;
      root_n = {root_q[VAL_W-2:0], 1'b1};
    end else begin
      rem_n  = rem_sh;
      root_n = {root_q[VAL_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        U_IDLE: begin
          if (start_i) state_q <= U_GRAD;
        end
        U_GRAD: state_q <= U_SQX;
        U_SQX:  state_q <= U_SQY;
        U_SQY: begin
          cnt_q   <= '0;
          state_q <= (thresh_i != '0) ? U_DONE : U_ROOT;
        end
        U_ROOT: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(ROOT_STEPS - 1)) state_q <= U_DONE;
        end
        U_DONE:  state_q <= U_IDLE;
        default: state_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (start_i) win_q <= win_i;
      end
      U_GRAD: begin
        ax_q <= gx[10] ? 10'(-gx) : gx[9:0];
        ay_q <= gy[10] ? 10'(-gy) : gy[9:0];
        t2_q <= thresh_i * thresh_i;
      end
      U_SQX: sq_q <= SQ_W'(ax_q * ax_q);
      U_SQY: begin
        sq_q   <= sq_y;
        rad_q  <= sq_y;
        rem_q  <= '0;
        root_q <= '0;
        val_q  <= (sq_y > {t2_q, 6'b0}) ? VAL_W'(1) : '0;
      end
      U_ROOT: begin
        rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
        rem_q  <= rem_n;
        root_q <= root_n;
        if (cnt_q == 4'(ROOT_STEPS - 1)) val_q <= (root_n > MAG_CLAMP) ? MAG_CLAMP : root_n;
      end
      default: ;
    endcase
  end

  assign rsp_o.done  = (state_q == U_DONE);
  assign rsp_o.value = val_q;

endmodule
